[sv/lbc_pkg.sv]
// Shared constants and types for the line-box clipping block.
package lbc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW = 32;
	localparam int DIFF_W = DW + 2;
	localparam int MAG_W = DW + 1;
	localparam int NUM_W = MAG_W + FRAC_BITS;
	localparam int LANE_LAT = NUM_W + 2;
	localparam int TOTAL_LAT = NUM_W + 6;
	localparam int NUM_REGS = 6;
	localparam int IDX_W = 3;

	typedef enum logic [1:0] {
		HIT_NONE  = 2'd0,
		HIT_POINT = 2'd1,
		HIT_SEG   = 2'd2
	} hit_t;

	typedef enum logic [IDX_W-1:0] {
		REG_X_MIN = 3'd0,
		REG_X_MAX = 3'd1,
		REG_Y_MIN = 3'd2,
		REG_Y_MAX = 3'd3,
		REG_Z_MIN = 3'd4,
		REG_Z_MAX = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][DW-1:0] pos;
		logic [2:0][DW-1:0] dir;
		logic               su;
		logic               eu;
	} item_t;

	typedef struct packed {
		hit_t           kind;
		logic [DW-1:0]  tmin;
		logic [DW-1:0]  tmax;
		item_t          item;
	} clip_t;

endpackage

[sv/lbc_div_lane.sv]
// One slab-bound lane: bound minus origin, pipelined restoring divide and saturation.
module lbc_div_lane
	import lbc_pkg::*;
(
	input  logic          clk,
	input  logic [DW-1:0] pos,
	input  logic [DW-1:0] dir,
	input  logic [DW-1:0] bound_pos,
	input  logic [DW-1:0] bound_neg,
	output logic [DW-1:0] t_out
);

	logic [DW-1:0]    rem_q [NUM_W+1];
	logic [NUM_W-1:0] num_q [NUM_W+1];
	logic [NUM_W-1:0] quo_q [NUM_W+1];
	logic [DW-1:0]    den_q [NUM_W+1];
	logic             neg_q [NUM_W+1];

	logic              dir_neg;
	logic [DW-1:0]     bound;
	logic [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0] diff_abs;
	logic [DW-1:0]     den;

	always_comb begin
		dir_neg  = dir[DW-1];
		bound    = dir_neg ? bound_neg : bound_pos;
		diff     = {{2{bound[DW-1]}}, bound} - {{2{pos[DW-1]}}, pos};
		diff_abs = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
		den      = dir_neg ? (~dir + DW'(1)) : dir;
	end

	always_ff @(posedge clk) begin
		rem_q[0] <= '0;
		num_q[0] <= {diff_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
		quo_q[0] <= '0;
		den_q[0] <= den;
		neg_q[0] <= diff[DIFF_W-1] ^ dir_neg;
	end

	for (genvar j = 1; j <= NUM_W; j++) begin : g_stage
		logic [MAG_W-1:0] shifted;
		logic             fits;
		always_comb begin
			shifted = {rem_q[j-1], num_q[j-1][NUM_W-1]};
			fits    = shifted >= {1'b0, den_q[j-1]};
		end
		always_ff @(posedge clk) begin
			rem_q[j] <= fits ? DW'(shifted - {1'b0, den_q[j-1]}) : shifted[DW-1:0];
			num_q[j] <= {num_q[j-1][NUM_W-2:0], 1'b0};
			quo_q[j] <= {quo_q[j-1][NUM_W-2:0], fits};
			den_q[j] <= den_q[j-1];
			neg_q[j] <= neg_q[j-1];
		end
	end

	logic [NUM_W-1:0] q;
	logic [DW-1:0]    sat;

	always_comb begin
		q = quo_q[NUM_W];
		if (neg_q[NUM_W]) begin
			if (q > NUM_W'(64'h8000_0000))
				sat = {1'b1, {(DW-1){1'b0}}};
			else
				sat = DW'(~q + NUM_W'(1));
		end else begin
			if (q > NUM_W'(64'h7FFF_FFFF))
				sat = {1'b0, {(DW-1){1'b1}}};
			else
				sat = q[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		t_out <= sat;
	end

endmodule

[sv/lbc_merge.sv]
// Merges the per-axis entry and exit parameters into one interval and a hit kind.
module lbc_merge
	import lbc_pkg::*;
(
	input  logic                  clk,
	input  logic [2:0][DW-1:0]    enter,
	input  logic [2:0][DW-1:0]    leave,
	input  logic [5:0][DW-1:0]    box,
	input  item_t                 item,
	output clip_t                 res
);

	logic signed [DW-1:0] tmin;
	logic signed [DW-1:0] tmax;
	logic                 minf;
	logic                 maxf;
	logic                 empty;
	hit_t                 kind;

	always_comb begin
		tmin  = '0;
		tmax  = DW'(64'd1 << FRAC_BITS);
		minf  = item.su;
		maxf  = item.eu;
		empty = 1'b0;
		for (int a = 0; a < 3; a++) begin
			if (!empty) begin
				if (item.dir[a] == '0) begin
					empty = ($signed(item.pos[a]) < $signed(box[2*a])) ||
						($signed(item.pos[a]) > $signed(box[2*a+1]));
				end else begin
					if (minf || ($signed(enter[a]) > tmin))
						tmin = $signed(enter[a]);
					if (maxf || ($signed(leave[a]) < tmax))
						tmax = $signed(leave[a]);
					minf  = 1'b0;
					maxf  = 1'b0;
					empty = tmax < tmin;
				end
			end
		end
		if (!empty && (minf || maxf))
			tmax = '0;
		if (empty)
			kind = HIT_NONE;
		else if (tmax == tmin)
			kind = HIT_POINT;
		else
			kind = HIT_SEG;
	end

	always_ff @(posedge clk) begin
		res.kind <= kind;
		res.tmin <= tmin;
		res.tmax <= tmax;
		res.item <= item;
	end

endmodule

[sv/lbc_endpt.sv]
// Endpoint stage: multiplies direction by parameter, then shifts, adds and saturates.
module lbc_endpt
	import lbc_pkg::*;
(
	input  logic                clk,
	input  clip_t               res,
	output hit_t                kind,
	output logic [2:0][DW-1:0]  first,
	output logic [2:0][DW-1:0]  last
);

	logic signed [2*DW-1:0] pf_s1 [3];
	logic signed [2*DW-1:0] pl_s1 [3];
	logic [2:0][DW-1:0]     pos_s1;
	hit_t                   kind_s1;

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			pf_s1[a] <= $signed(res.item.dir[a]) * $signed(res.tmin);
			pl_s1[a] <= $signed(res.item.dir[a]) * $signed(res.tmax);
		end
		pos_s1  <= res.item.pos;
		kind_s1 <= res.kind;
	end

	function automatic logic [DW-1:0] sat_add(logic [DW-1:0] p, logic signed [2*DW-1:0] m);
		logic signed [2*DW:0] s;
		s = 65'($signed(p)) + 65'(m >>> FRAC_BITS);
		if (s > 65'sh0_7FFF_FFFF)
			return {1'b0, {(DW-1){1'b1}}};
		else if (s < -65'sh0_8000_0000)
			return {1'b1, {(DW-1){1'b0}}};
		else
			return s[DW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		kind <= kind_s1;
		for (int a = 0; a < 3; a++) begin
			first[a] <= (kind_s1 == HIT_NONE) ? '0 : sat_add(pos_s1[a], pf_s1[a]);
			last[a]  <= (kind_s1 == HIT_SEG) ? sat_add(pos_s1[a], pl_s1[a]) : '0;
		end
	end

endmodule

[sv/line_box_clip_3d_top.sv]
// Top level of the line-box clipping block.
//
// Each item is a line (origin, step, two unbounded flags) clipped against the
// box held in six configuration registers by the slab method.
// An item is taken at a rising edge with start high; busy is always low, so a
// new item may follow in every cycle and the block sustains one item per
// cycle.
// Six divider lanes, one per slab bound, each a 49-stage restoring divider,
// run side by side; a merge stage forms the interval and an endpoint stage
// multiplies and saturates.
// The result reaches the output ports through the divider lanes, the merge stage
// and the endpoint stage, with done high for exactly one cycle; the receiver
// cannot stall it.
// Configuration writes (cfg_we, cfg_index, cfg_data) apply at the next edge;
// the user makes them only while no item is in flight; no check in the block.
// Reset clears the box registers to zero and drops all items in flight.
module line_box_clip_3d_top
	import lbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [31:0]   origin_x,
	input  logic signed [31:0]   origin_y,
	input  logic signed [31:0]   origin_z,
	input  logic signed [31:0]   step_x,
	input  logic signed [31:0]   step_y,
	input  logic signed [31:0]   step_z,
	input  logic                 start_unbounded,
	input  logic                 end_unbounded,
	input  logic                 cfg_we,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [DW-1:0]        cfg_data,
	output logic                 done,
	output logic [1:0]           hit_kind,
	output logic signed [31:0]   first_x,
	output logic signed [31:0]   first_y,
	output logic signed [31:0]   first_z,
	output logic signed [31:0]   last_x,
	output logic signed [31:0]   last_y,
	output logic signed [31:0]   last_z
);

	logic [5:0][DW-1:0]    box_q;
	logic [TOTAL_LAT-1:0]  vld_q;
	item_t                 item_s1;
	item_t                 side_q [LANE_LAT];
	logic [2:0][DW-1:0]    enter;
	logic [2:0][DW-1:0]    leave;
	clip_t                 res;
	hit_t                  kind;
	logic [2:0][DW-1:0]    first;
	logic [2:0][DW-1:0]    last;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_MIN: box_q[0] <= cfg_data;
				REG_X_MAX: box_q[1] <= cfg_data;
				REG_Y_MIN: box_q[2] <= cfg_data;
				REG_Y_MAX: box_q[3] <= cfg_data;
				REG_Z_MIN: box_q[4] <= cfg_data;
				REG_Z_MAX: box_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], start && !busy};
		end
	end

	always_ff @(posedge clk) begin
		item_s1.pos <= {origin_z, origin_y, origin_x};
		item_s1.dir <= {step_z, step_y, step_x};
		item_s1.su  <= start_unbounded;
		item_s1.eu  <= end_unbounded;
		side_q[0]   <= item_s1;
		for (int i = 1; i < LANE_LAT; i++)
			side_q[i] <= side_q[i-1];
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		lbc_div_lane u_enter (
			.clk       (clk),
			.pos       (item_s1.pos[a]),
			.dir       (item_s1.dir[a]),
			.bound_pos (box_q[2*a]),
			.bound_neg (box_q[2*a+1]),
			.t_out     (enter[a])
		);
		lbc_div_lane u_leave (
			.clk       (clk),
			.pos       (item_s1.pos[a]),
			.dir       (item_s1.dir[a]),
			.bound_pos (box_q[2*a+1]),
			.bound_neg (box_q[2*a]),
			.t_out     (leave[a])
		);
	end

	lbc_merge u_merge (
		.clk   (clk),
		.enter (enter),
		.leave (leave),
		.box   (box_q),
		.item  (side_q[LANE_LAT-1]),
		.res   (res)
	);

	lbc_endpt u_endpt (
		.clk   (clk),
		.res   (res),
		.kind  (kind),
		.first (first),
		.last  (last)
	);

	assign done     = vld_q[TOTAL_LAT-1];
	assign hit_kind = kind;
	assign first_x  = first[0];
	assign first_y  = first[1];
	assign first_z  = first[2];
	assign last_x   = last[0];
	assign last_y   = last[1];
	assign last_z   = last[2];

endmodule

[sv/lbc_checker.sv]
// Port-level checker for the line-box clipping block and its bind.
module lbc_checker
	import lbc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  hit_kind,
	input logic [31:0] first_x,
	input logic [31:0] first_y,
	input logic [31:0] first_z,
	input logic [31:0] last_x,
	input logic [31:0] last_y,
	input logic [31:0] last_z
);

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(TOTAL_LAT) done)
		else $error("item result missing");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hit_kind == HIT_NONE || hit_kind == HIT_POINT || hit_kind == HIT_SEG))
		else $error("bad hit kind");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit_kind == HIT_NONE |->
		first_x == 0 && first_y == 0 && first_z == 0 &&
		last_x == 0 && last_y == 0 && last_z == 0)
		else $error("miss with nonzero coordinates");

	a_point_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit_kind == HIT_POINT |-> last_x == 0 && last_y == 0 && last_z == 0)
		else $error("point with nonzero end");

endmodule

bind line_box_clip_3d_top lbc_checker u_lbc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.hit_kind (hit_kind),
	.first_x  (first_x),
	.first_y  (first_y),
	.first_z  (first_z),
	.last_x   (last_x),
	.last_y   (last_y),
	.last_z   (last_z)
);

[dv/tb_line_box_clip_3d_top.sv]
// Self-checking testbench for the line-box clipping block with a built-in slab-method predictor.
module tb_line_box_clip_3d_top;
	import lbc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [31:0] ox, oy, oz, sx, sy, sz;
		logic su, eu;
	} line_t;

	typedef struct {
		hit_t kind;
		logic signed [31:0] fx, fy, fz, lx, ly, lz;
	} clip_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [31:0] step_x = '0, step_y = '0, step_z = '0;
	logic start_unbounded = 1'b0, end_unbounded = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [DW-1:0] cfg_data = '0;
	logic done;
	logic [1:0] hit_kind;
	logic signed [31:0] first_x, first_y, first_z, last_x, last_y, last_z;

	line_box_clip_3d_top dut (.*);

	line_t pending_lines[$];
	clip_res_t expected_clips[$];
	longint box_bound[NUM_REGS];
	int n_errors = 0;
	int n_checked = 0;
	int n_hits[3] = '{0, 0, 0};
	int gap_left = 0;

	initial forever #5 clk = ~clk;

	function automatic longint slab_div(longint num, longint den);
		longint n, d, q;
		n = (num < 0 ? -num : num) << FRAC_BITS;
		d = den < 0 ? -den : den;
		q = n / d;
		if ((num < 0) != (den < 0))
			return (q > 64'h80000000) ? -64'sd2147483648 : -q;
		return (q > 64'sd2147483647) ? 64'sd2147483647 : q;
	endfunction

	function automatic logic signed [31:0] line_point(longint p, longint d, longint t);
		longint v;
		v = p + ((d * t) >>> FRAC_BITS);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic clip_res_t predict_clip(line_t ln);
		clip_res_t r;
		longint p[3], d[3], lo, hi, t_in, t_out, tmin, tmax;
		logic minf, maxf, empty;
		p[0] = ln.ox; p[1] = ln.oy; p[2] = ln.oz;
		d[0] = ln.sx; d[1] = ln.sy; d[2] = ln.sz;
		tmin = 0; tmax = 64'sd1 << FRAC_BITS;
		minf = ln.su; maxf = ln.eu; empty = 1'b0;
		r = '{HIT_NONE, 0, 0, 0, 0, 0, 0};
		for (int i = 0; i < 3 && !empty; i++) begin
			lo = box_bound[2*i];
			hi = box_bound[2*i+1];
			if (d[i] == 0) begin
				empty = (p[i] < lo) || (p[i] > hi);
			end else begin
				if (d[i] > 0) begin
					t_in = slab_div(lo - p[i], d[i]);
					t_out = slab_div(hi - p[i], d[i]);
				end else begin
					t_in = slab_div(hi - p[i], d[i]);
					t_out = slab_div(lo - p[i], d[i]);
				end
				if (minf) begin
					minf = 1'b0; tmin = t_in;
				end else if (t_in > tmin) tmin = t_in;
				if (maxf) begin
					maxf = 1'b0; tmax = t_out;
				end else if (t_out < tmax) tmax = t_out;
				empty = tmax < tmin;
			end
		end
		if (!empty) begin
			if (minf || maxf) tmax = 0;
			if (tmax == tmin) begin
				r.kind = HIT_POINT;
				r.fx = line_point(p[0], d[0], tmax);
				r.fy = line_point(p[1], d[1], tmax);
				r.fz = line_point(p[2], d[2], tmax);
			end else begin
				r.kind = HIT_SEG;
				r.fx = line_point(p[0], d[0], tmin);
				r.fy = line_point(p[1], d[1], tmin);
				r.fz = line_point(p[2], d[2], tmin);
				r.lx = line_point(p[0], d[0], tmax);
				r.ly = line_point(p[1], d[1], tmax);
				r.lz = line_point(p[2], d[2], tmax);
			end
		end
		return r;
	endfunction

	// Driver: takes lines from the pending queue with random gaps.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			expected_clips.push_back(predict_clip('{origin_x, origin_y, origin_z,
				step_x, step_y, step_z, start_unbounded, end_unbounded}));
		end
		if (!arst_n || (start && busy)) begin
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (pending_lines.size() > 0) begin
			line_t ln;
			ln = pending_lines.pop_front();
			origin_x <= ln.ox; origin_y <= ln.oy; origin_z <= ln.oz;
			step_x <= ln.sx; step_y <= ln.sy; step_z <= ln.sz;
			start_unbounded <= ln.su; end_unbounded <= ln.eu;
			start <= 1'b1;
			gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
		end else begin
			start <= 1'b0;
		end
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			n_errors++;
		end
	endtask

	// Monitor: compares every result with the oldest predicted one.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_clips.size() == 0) begin
				$error("hit_kind: expected nothing, got %0d", hit_kind);
				n_errors++;
			end else begin
				clip_res_t e;
				e = expected_clips.pop_front();
				check_field("hit_kind", e.kind, hit_kind);
				check_field("first_x", e.fx, first_x);
				check_field("first_y", e.fy, first_y);
				check_field("first_z", e.fz, first_z);
				check_field("last_x", e.lx, last_x);
				check_field("last_y", e.ly, last_y);
				check_field("last_z", e.lz, last_z);
				if (e.kind <= HIT_SEG) n_hits[e.kind]++;
				n_checked++;
			end
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return $urandom;
			default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
		endcase
	endfunction

	function automatic logic [31:0] rand_step();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			3: return $urandom;
			4: return $signed($urandom_range(0, 15)) - 8;
			default: return $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
		endcase
	endfunction

	task automatic write_box(reg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		box_bound[idx] = longint'($signed(v));
	endtask

	task automatic set_box(logic [31:0] x0, x1, y0, y1, z0, z1);
		write_box(REG_X_MIN, x0); write_box(REG_X_MAX, x1);
		write_box(REG_Y_MIN, y0); write_box(REG_Y_MAX, y1);
		write_box(REG_Z_MIN, z0); write_box(REG_Z_MAX, z1);
	endtask

	task automatic drain();
		wait (pending_lines.size() == 0 && !start && expected_clips.size() == 0);
		repeat (TOTAL_LAT + 10) @(posedge clk);
	endtask

	task automatic queue_line(logic [31:0] ox, oy, oz, sx, sy, sz, logic su, eu);
		pending_lines.push_back('{ox, oy, oz, sx, sy, sz, su, eu});
	endtask

	initial begin
		for (int i = 0; i < NUM_REGS; i++) box_bound[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// Reset box is a single point at the origin.
		queue_line(0, 0, 0, 0, 0, 0, 0, 0);
		queue_line(0, 0, 0, 0, 0, 0, 1, 0);
		queue_line(32'hffff0000, 0, 0, 32'h20000, 0, 0, 0, 0);
		drain();
		set_box(32'hfffe0000, 32'h20000, 32'hfffe0000, 32'h20000, 32'hfffe0000, 32'h20000);
		queue_line(0, 0, 0, 0, 0, 0, 0, 0);
		queue_line(0, 0, 0, 0, 0, 0, 0, 1);
		queue_line(0, 0, 0, 0, 0, 0, 1, 1);
		queue_line(32'h30000, 0, 0, 0, 0, 0, 0, 0);
		queue_line(32'hfffc0000, 0, 0, 32'h80000, 0, 0, 0, 0);
		queue_line(32'hfffc0000, 0, 0, 32'h80000, 0, 0, 1, 1);
		queue_line(0, 0, 0, 32'h10000, 32'hffff0000, 32'h8000, 1, 0);
		queue_line(0, 0, 0, 0, 0, 32'h10000, 0, 1);
		queue_line(32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff, 1, 1, 1);
		queue_line(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 0, 0);
		queue_line(32'h20000, 32'h20000, 32'h20000, 32'h10000, 0, 0, 0, 0);
		queue_line(32'h10000, 0, 0, 32'hffffffff, 1, 32'h80000000, 1, 1);
		queue_line(32'hfffb0000, 0, 0, 32'h10000, 0, 0, 0, 1);
		drain();
		set_box(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff);
		queue_line(32'h7fffffff, 32'h80000000, 0, 1, 32'hffffffff, 0, 1, 1);
		queue_line(0, 0, 0, 32'h7fffffff, 32'h80000000, 1, 0, 1);
		drain();
		// Inverted box.
		set_box(32'h10000, 32'hffff0000, 0, 0, 0, 0);
		queue_line(0, 0, 0, 32'h10000, 0, 0, 1, 1);
		queue_line(0, 0, 0, 0, 0, 0, 0, 0);
		drain();
		for (int phase = 0; phase < 13; phase++) begin
			logic [31:0] a, b;
			for (int k = 0; k < 3; k++) begin
				a = rand_coord();
				b = ($urandom_range(0, 9) == 0) ? rand_coord()
					: $signed(a) + $signed({1'b0, $urandom_range(0, 32'h0007ffff)});
				if ($signed(b) < $signed(a) && $urandom_range(0, 9) != 0) b = a;
				write_box(reg_idx_t'(2*k), a);
				write_box(reg_idx_t'(2*k+1), b);
			end
			for (int n = 0; n < 150; n++) begin
				logic [31:0] c[3];
				for (int k = 0; k < 3; k++) begin
					if ($urandom_range(0, 2) != 0)
						c[k] = $signed(32'(box_bound[2*k]))
							+ $signed($urandom_range(0, 32'h000fffff)) - 32'sh00040000;
					else
						c[k] = rand_coord();
				end
				queue_line(c[0], c[1], c[2], rand_step(), rand_step(), rand_step(),
					$urandom_range(0, 1), $urandom_range(0, 1));
			end
			drain();
		end
		$display("Checked %0d items over 17 box settings: %0d misses, %0d points, %0d segments.",
			n_checked, n_hits[0], n_hits[1], n_hits[2]);
		if (n_errors == 0 && expected_clips.size() == 0)
			$display("** line_box_clip_3d_top: PASSED **");
		else
			$display("** line_box_clip_3d_top: FAILED **");
		$finish;
	end

	initial begin
		#5ms;
		$display("** line_box_clip_3d_top: FAILED **");
		$finish;
	end

endmodule
